// File: rtl/gam_pkg.sv
package gam_pkg;

    localparam int unsigned CFG_W      = 15;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_CLOSED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DPAD_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_STEP      = 3'd6;

    // opcodes
    localparam logic [1:0] OP_BUTTON = 2'd0;
    localparam logic [1:0] OP_AXIS   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // button numbers
    localparam logic [7:0] BTN_ARM_DOWN   = 8'd0;
    localparam logic [7:0] BTN_PAN_UP     = 8'd1;
    localparam logic [7:0] BTN_PAN_DOWN   = 8'd3;
    localparam logic [7:0] BTN_ARM_UP     = 8'd4;
    localparam logic [7:0] BTN_GRIP_CLOSE = 8'd6;
    localparam logic [7:0] BTN_THIRD_UP   = 8'd7;
    localparam logic [7:0] BTN_GRIP_OPEN  = 8'd8;
    localparam logic [7:0] BTN_THIRD_DOWN = 8'd9;

    // axis numbers
    localparam logic [7:0] AXIS_TURN    = 8'd0;
    localparam logic [7:0] AXIS_FORWARD = 8'd1;
    localparam logic [7:0] AXIS_DPAD    = 8'd7;

    // result kinds
    localparam logic KIND_SERVO = 1'b0;
    localparam logic KIND_DRIVE = 1'b1;

    // servo indexes
    localparam logic [2:0] SRV_PAN     = 3'd1;
    localparam logic [2:0] SRV_ARM     = 3'd2;
    localparam logic [2:0] SRV_THIRD   = 3'd3;
    localparam logic [2:0] SRV_GRIPPER = 3'd4;
    localparam logic [2:0] SRV_TILT    = 3'd5;

    // drive directions
    localparam logic [2:0] DIR_STOP       = 3'd0;
    localparam logic [2:0] DIR_FORWARD    = 3'd1;
    localparam logic [2:0] DIR_BACKWARD   = 3'd2;
    localparam logic [2:0] DIR_RIGHT      = 3'd3;
    localparam logic [2:0] DIR_LEFT       = 3'd4;
    localparam logic [2:0] DIR_SPEED_ONLY = 3'd5;

    typedef struct packed {
        logic [14:0] dead_zone;
        logic [6:0]  press_step;
        logic [6:0]  servo_limit;
        logic [6:0]  gripper_step;
        logic [7:0]  gripper_closed;
        logic [14:0] dpad_threshold;
        logic [6:0]  tilt_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dead_zone:      15'd4915,
        press_step:     7'd5,
        servo_limit:    7'd80,
        gripper_step:   7'd2,
        gripper_closed: 8'hA6,
        dpad_threshold: 15'd16384,
        tilt_step:      7'd5
    };

    typedef struct packed {
        logic [7:0]  pan;
        logic [7:0]  arm;
        logic [7:0]  third;
        logic [7:0]  grip;
        logic [15:0] tilt;
        logic [16:0] fwd;
        logic [16:0] turn;
        logic        closing;
        logic        opening;
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  index;
        logic [15:0] angle;
        logic [2:0]  dir;
        logic [16:0] speed;
    } result_t;

endpackage

// File: rtl/gamepad_actuator_mapper.sv
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   event word: control_number, control_value; opcode in s_tuser
// m_*       out        m_tvalid/m_tready   command word, kind in m_tuser
// cfg_*     in         cfg_we              register write, index cfg_addr
//
// While s_tready is high, one event word is accepted per cycle; its command (if any)
// is registered into the output queue, behind any command still queued. A two-entry
// output queue lets a new word in while one command waits.
// s_tready drops only when both queue entries are full, even if m_tready is high then.
// rst_n clears state, flags and queue and loads the register defaults.
module gamepad_actuator_mapper
    import gam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // control_number[7:0], control_value[23:8]
    input  logic [1:0]           s_tuser,   // opcode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // servo_index[2:0], servo_angle[18:3],
                                            // drive_direction[21:19], drive_speed[38:22]
    output logic                 m_tuser,   // result_kind[0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t    cfg_reg;
    state_t  st_reg;
    state_t  st_next;
    logic    res_valid;
    result_t res;
    result_t q0_reg;
    result_t q1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic    accept;
    logic    push;
    logic    pop;
    logic [1:0] slot;

    gam_datapath u_datapath (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .op        (s_tuser),
        .num       (s_tdata[7:0]),
        .val       (s_tdata[23:8]),
        .st_next   (st_next),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_tready = (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && res_valid;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign slot     = cnt_reg - {1'b0, pop};
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    assign m_tuser = q0_reg.kind;
    assign m_tdata = {1'b0, q0_reg.speed, q0_reg.dir, q0_reg.angle, q0_reg.index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEAD_ZONE:      cfg_reg.dead_zone      <= cfg_wdata[14:0];
                REG_PRESS_STEP:     cfg_reg.press_step     <= cfg_wdata[6:0];
                REG_SERVO_LIMIT:    cfg_reg.servo_limit    <= cfg_wdata[6:0];
                REG_GRIPPER_STEP:   cfg_reg.gripper_step   <= cfg_wdata[6:0];
                REG_GRIPPER_CLOSED: cfg_reg.gripper_closed <= cfg_wdata[7:0];
                REG_DPAD_THRESHOLD: cfg_reg.dpad_threshold <= cfg_wdata[14:0];
                REG_TILT_STEP:      cfg_reg.tilt_step      <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue payload: shift on pop, then the pushed word lands behind what remains
    always_ff @(posedge clk)
    begin
        if (pop)
            q0_reg <= q1_reg;
        if (push)
        begin
            if (slot == 2'd0)
                q0_reg <= res;
            else
                q1_reg <= res;
        end
    end

endmodule

// File: rtl/gam_datapath.sv
module gam_datapath
    import gam_pkg::*;
(
    input  state_t      st,
    input  cfg_t        cfg,
    input  logic [1:0]  op,
    input  logic [7:0]  num,
    input  logic [15:0] val,
    output state_t      st_next,
    output logic        res_valid,
    output result_t     res
);

    function automatic logic [7:0] step_up(input logic [7:0] a, input logic [6:0] step,
                                           input logic [6:0] limit);
        logic signed [9:0] v;
        logic signed [9:0] lim;
        v   = $signed({{2{a[7]}}, a}) + $signed({3'b000, step});
        lim = $signed({3'b000, limit});
        return (v < lim) ? v[7:0] : lim[7:0];
    endfunction

    function automatic logic [7:0] step_down(input logic [7:0] a, input logic [6:0] step,
                                             input logic [6:0] limit);
        logic signed [9:0] v;
        logic signed [9:0] lim;
        v   = $signed({{2{a[7]}}, a}) - $signed({3'b000, step});
        lim = -$signed({3'b000, limit});
        return (v > lim) ? v[7:0] : lim[7:0];
    endfunction

    function automatic logic [16:0] abs17(input logic [16:0] x);
        return x[16] ? 17'(-x) : x;
    endfunction

    function automatic logic [16:0] abs18(input logic [17:0] x);
        logic [17:0] m;
        m = x[17] ? 18'(-x) : x;
        return m[16:0];
    endfunction

    function automatic result_t servo_res(input logic [2:0] idx, input logic [15:0] ang);
        result_t sr;
        sr       = '0;
        sr.kind  = KIND_SERVO;
        sr.index = idx;
        sr.angle = ang;
        return sr;
    endfunction

    logic        press;
    logic [16:0] neg_val;
    logic [16:0] val_abs;
    logic [16:0] f;
    logic [16:0] t;
    logic [17:0] l;
    logic [17:0] r;
    logic [16:0] al;
    logic [16:0] ar;
    logic        l_pos, l_neg, r_pos, r_neg;
    logic        idle;
    result_t     drive_res;
    logic signed [9:0] grip_dn;
    logic signed [9:0] grip_up;
    logic [7:0]  grip_dn_sat;
    logic [7:0]  grip_up_sat;
    logic [15:0] tilt_new;

    assign press   = (val != 16'd0);
    assign neg_val = 17'(-$signed({val[15], val}));
    assign val_abs = abs17({val[15], val});

    // drive uses the axis value just written
    assign f = (op == OP_AXIS && num == AXIS_FORWARD) ? neg_val : st.fwd;
    assign t = (op == OP_AXIS && num == AXIS_TURN) ? neg_val : st.turn;
    assign l = {f[16], f} - {t[16], t};
    assign r = {f[16], f} + {t[16], t};
    assign al = abs18(l);
    assign ar = abs18(r);
    assign l_pos = !l[17] && (l != 18'd0);
    assign l_neg = l[17];
    assign r_pos = !r[17] && (r != 18'd0);
    assign r_neg = r[17];
    assign idle  = (abs17(f) < {2'b00, cfg.dead_zone}) && (abs17(t) < {2'b00, cfg.dead_zone});

    always_comb
    begin
        drive_res      = '0;
        drive_res.kind = KIND_DRIVE;
        if (idle)
        begin
            drive_res.dir = DIR_STOP;
        end
        else
        begin
            drive_res.speed = (al > ar) ? al : ar;
            if (l_pos && r_pos)
                drive_res.dir = DIR_FORWARD;
            else if (l_neg && r_neg)
                drive_res.dir = DIR_BACKWARD;
            else if (l_pos && r_neg)
                drive_res.dir = DIR_RIGHT;
            else if (l_neg && r_pos)
                drive_res.dir = DIR_LEFT;
            else
                drive_res.dir = DIR_SPEED_ONLY;
        end
    end

    assign grip_dn     = $signed({{2{st.grip[7]}}, st.grip}) - $signed({3'b000, cfg.gripper_step});
    assign grip_up     = $signed({{2{st.grip[7]}}, st.grip}) + $signed({3'b000, cfg.gripper_step});
    assign grip_dn_sat = (grip_dn < -10'sd128) ? 8'h80 : grip_dn[7:0];
    assign grip_up_sat = (grip_up > 10'sd127) ? 8'h7F : grip_up[7:0];

    assign tilt_new = val[15] || !press ? st.tilt - {9'd0, cfg.tilt_step}
                                        : st.tilt + {9'd0, cfg.tilt_step};

    always_comb
    begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;
        case (op)
            OP_BUTTON:
            begin
                case (num)
                    BTN_GRIP_CLOSE:
                    begin
                        st_next.closing = (val == 16'd1);
                        st_next.opening = 1'b0;
                    end
                    BTN_GRIP_OPEN:
                    begin
                        st_next.opening = (val == 16'd1);
                        st_next.closing = 1'b0;
                    end
                    BTN_ARM_UP, BTN_ARM_DOWN:
                    begin
                        if (press)
                        begin
                            st_next.arm = (num == BTN_ARM_UP)
                                ? step_up(st.arm, cfg.press_step, cfg.servo_limit)
                                : step_down(st.arm, cfg.press_step, cfg.servo_limit);
                            res_valid = 1'b1;
                            res = servo_res(SRV_ARM, {{8{st_next.arm[7]}}, st_next.arm});
                        end
                    end
                    BTN_PAN_UP, BTN_PAN_DOWN:
                    begin
                        if (press)
                        begin
                            st_next.pan = (num == BTN_PAN_UP)
                                ? step_up(st.pan, cfg.press_step, cfg.servo_limit)
                                : step_down(st.pan, cfg.press_step, cfg.servo_limit);
                            res_valid = 1'b1;
                            res = servo_res(SRV_PAN, {{8{st_next.pan[7]}}, st_next.pan});
                        end
                    end
                    BTN_THIRD_UP, BTN_THIRD_DOWN:
                    begin
                        if (press)
                        begin
                            st_next.third = (num == BTN_THIRD_UP)
                                ? step_up(st.third, cfg.press_step, cfg.servo_limit)
                                : step_down(st.third, cfg.press_step, cfg.servo_limit);
                            res_valid = 1'b1;
                            res = servo_res(SRV_THIRD, {{8{st_next.third[7]}}, st_next.third});
                        end
                    end
                    default: ;
                endcase
            end
            OP_AXIS:
            begin
                case (num)
                    AXIS_FORWARD, AXIS_TURN:
                    begin
                        st_next.fwd  = f;
                        st_next.turn = t;
                        res_valid    = 1'b1;
                        res          = drive_res;
                    end
                    AXIS_DPAD:
                    begin
                        if (val_abs >= {2'b00, cfg.dpad_threshold})
                        begin
                            st_next.tilt = tilt_new;
                            res_valid    = 1'b1;
                            res          = servo_res(SRV_TILT, tilt_new);
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (st.closing && ($signed(st.grip) > $signed(cfg.gripper_closed)))
                begin
                    st_next.grip = grip_dn_sat;
                    res_valid    = 1'b1;
                    res          = servo_res(SRV_GRIPPER, {{8{grip_dn_sat[7]}}, grip_dn_sat});
                end
                else if (st.opening && st.grip[7])
                begin
                    st_next.grip = grip_up_sat;
                    res_valid    = 1'b1;
                    res          = servo_res(SRV_GRIPPER, {{8{grip_up_sat[7]}}, grip_up_sat});
                end
            end
            default: ;
        endcase
    end

endmodule
